// ===== hdl/fpl_pkg.sv =====
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared types and constants of the frame pacing limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpl_pkg;

	// field widths
	localparam int SPEED_W  = 10;
	localparam int PERIOD_W = 20;
	localparam int COUNT_W  = 16;
	localparam int TIME_W   = 48;
	localparam int WAIT_W   = 31;
	localparam int ADJ_W    = 32;
	localparam int OP_W     = 3;

	// timing constants
	localparam int US_PER_SECOND = 1000000;
	localparam int LATE_LIMIT_US = 70000;
	localparam int DEFAULT_SPEED = 60;
	localparam int MID_BAND      = 15;
	localparam int STEP_HI       = 10;
	localparam int STEP_MID      = 5;
	localparam int STEP_LO       = 1;
	localparam int MAX_SPEED_DEF = 1000;
	localparam int RESET_PERIOD  = US_PER_SECOND / DEFAULT_SPEED;

	// event codes
	typedef enum logic [OP_W-1:0] {
		OP_FRAME      = 3'd0,
		OP_SPEED_UP   = 3'd1,
		OP_SPEED_DOWN = 3'd2,
		OP_SET_SPEED  = 3'd3,
		OP_RESTART    = 3'd4,
		OP_ADJUST     = 3'd5
	} op_t;

	// frame counting phase
	typedef enum logic [1:0] {
		PH_RUNNING,
		PH_SKIP,
		PH_RESYNC
	} phase_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DUE,
		ST_DIFF,
		ST_FINISH,
		ST_DIV_WAIT,
		ST_CFG_WAIT,
		ST_EMIT
	} ctrl_state_t;

	// datapath step commands
	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_DECODE,
		CMD_MUL,
		CMD_DUE,
		CMD_DIFF,
		CMD_FINISH
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t step;
		logic    in_ready;
		logic    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic frame_skip;
		logic frame_short;
		logic div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fpl_div.sv =====
// ----------------------------------------------------------------------------
// fpl_div
// Restoring divider: one million by the speed, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [fpl_pkg::SPEED_W-1:0]     divisor,
	output logic                                 done,
	output logic      [fpl_pkg::PERIOD_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(fpl_pkg::PERIOD_W);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [fpl_pkg::PERIOD_W-1:0]    dvd_q;
	logic [fpl_pkg::SPEED_W-1:0]     dvs_q;
	logic [fpl_pkg::SPEED_W-1:0]     rem_q;
	logic [fpl_pkg::SPEED_W:0]       rem_sh;
	logic                            ge;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q, dvd_q[fpl_pkg::PERIOD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(fpl_pkg::PERIOD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= fpl_pkg::PERIOD_W'(fpl_pkg::US_PER_SECOND);
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? fpl_pkg::SPEED_W'(rem_sh - {1'b0, dvs_q})
				: rem_sh[fpl_pkg::SPEED_W-1:0];
			dvd_q <= {dvd_q[fpl_pkg::PERIOD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ===== hdl/fpl_dp.sv =====
// ----------------------------------------------------------------------------
// fpl_dp
// Pacer datapath: speed and period state, window bookkeeping, due time math.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_dp #(
	parameter int MAX_SPEED = fpl_pkg::MAX_SPEED_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fpl_pkg::ctrl_cmd_t                 cmd,
	output fpl_pkg::dp_stat_t                       stat,
	input  wire logic                               cfg_wr,
	input  wire logic        [fpl_pkg::SPEED_W-1:0] cfg_hertz,
	input  wire logic        [fpl_pkg::OP_W-1:0]    op,
	input  wire logic        [fpl_pkg::TIME_W-1:0]  now_us,
	input  wire logic        [fpl_pkg::SPEED_W-1:0] speed_value,
	input  wire logic signed [fpl_pkg::ADJ_W-1:0]   adjust_us,
	output logic             [fpl_pkg::WAIT_W-1:0]  res_wait,
	output logic                                    res_done,
	output logic                                    res_valid,
	output logic             [fpl_pkg::COUNT_W-1:0] res_fps,
	output logic             [fpl_pkg::SPEED_W-1:0] res_speed
);

	localparam int SW   = fpl_pkg::SPEED_W;
	localparam int TW   = fpl_pkg::TIME_W;
	localparam int CW   = fpl_pkg::COUNT_W;
	localparam int PW   = fpl_pkg::PERIOD_W;
	localparam int WW   = fpl_pkg::WAIT_W;
	localparam int PRW  = PW + CW;
	localparam int DW   = TW + 1;
	localparam int XW   = TW + 2;
	localparam logic [SW-1:0] SPEED_MAX = SW'(MAX_SPEED);

	function automatic logic [SW-1:0] clamp_speed(input logic [SW:0] s);
		logic [SW-1:0] r;
		if (s == '0)
			r = SW'(1);
		else if (s > {1'b0, SPEED_MAX})
			r = SPEED_MAX;
		else
			r = s[SW-1:0];
		return r;
	endfunction

	// latched request
	fpl_pkg::op_t            op_q;
	logic [TW-1:0]           now_q;
	logic [SW-1:0]           req_q;
	logic [fpl_pkg::ADJ_W-1:0] adj_q;

	// pacer state
	logic [SW-1:0]           target_q;
	logic [PW-1:0]           period_q;
	logic [CW-1:0]           count_q;
	fpl_pkg::phase_t         phase_q;
	logic [TW-1:0]           start_q;

	// frame pipeline
	logic [PRW-1:0]          prod_s1;
	logic                    early_close_s1;
	logic [DW-1:0]           due_s2;
	logic [XW-1:0]           diff_s3;

	// result
	logic [WW-1:0]           wait_q;
	logic                    done_q;
	logic                    valid_q;
	logic [CW-1:0]           fps_q;

	logic                    div_start;
	logic [SW-1:0]           div_divisor;
	logic                    div_done;
	logic [PW-1:0]           div_quot;

	logic [CW-1:0]           count_new;
	logic [TW-1:0]           start_eff;
	logic [SW-1:0]           step;
	logic [SW-1:0]           speed_new;
	logic                    speed_op;
	logic                    early;
	logic [DW-1:0]           ahead;
	logic [WW-1:0]           wait_sat;
	logic                    close;
	logic [TW-1:0]           start_next;

	// frame count and window start seen by a frame
	always_comb begin
		if (phase_q == fpl_pkg::PH_RESYNC) begin
			count_new = CW'(1);
			start_eff = now_q;
		end else begin
			count_new = (count_q == '1) ? count_q : count_q + 1'b1;
			start_eff = start_q;
		end
	end

	// speed step by band and the new target speed
	always_comb begin
		if (target_q >= SW'(fpl_pkg::DEFAULT_SPEED))
			step = SW'(fpl_pkg::STEP_HI);
		else if (target_q >= SW'(fpl_pkg::MID_BAND))
			step = SW'(fpl_pkg::STEP_MID);
		else
			step = SW'(fpl_pkg::STEP_LO);
		speed_op = 1'b1;
		case (op_q)
			fpl_pkg::OP_SPEED_UP:
				speed_new = clamp_speed({1'b0, target_q} + {1'b0, step});
			fpl_pkg::OP_SPEED_DOWN:
				speed_new = (target_q > step) ? target_q - step : SW'(1);
			fpl_pkg::OP_SET_SPEED:
				speed_new = clamp_speed({1'b0, req_q});
			default: begin
				speed_new = target_q;
				speed_op  = 1'b0;
			end
		endcase
	end

	// divider start on a hertz write or a speed event
	always_comb begin
		div_start   = cfg_wr || (cmd.step == fpl_pkg::CMD_DECODE && speed_op);
		div_divisor = cfg_wr ? clamp_speed({1'b0, cfg_hertz}) : speed_new;
	end

	fpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// early or late, and the window close decision
	always_comb begin
		early      = diff_s3[XW-1];
		ahead      = DW'(~diff_s3 + 1'b1);
		wait_sat   = (ahead > DW'({WW{1'b1}})) ? {WW{1'b1}} : ahead[WW-1:0];
		if (early) begin
			close      = early_close_s1;
			start_next = due_s2[TW-1:0];
		end else begin
			close      = diff_s3 > XW'(fpl_pkg::LATE_LIMIT_US);
			start_next = now_q;
		end
	end

	// pacer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= SW'(fpl_pkg::DEFAULT_SPEED);
			period_q <= PW'(fpl_pkg::RESET_PERIOD);
			count_q  <= '0;
			phase_q  <= fpl_pkg::PH_RUNNING;
			start_q  <= '0;
		end else begin
			if (div_done)
				period_q <= div_quot;
			if (cfg_wr) begin
				target_q <= div_divisor;
				count_q  <= '0;
				phase_q  <= fpl_pkg::PH_RUNNING;
			end else if (cmd.step == fpl_pkg::CMD_DECODE) begin
				case (op_q)
					fpl_pkg::OP_FRAME: begin
						if (phase_q == fpl_pkg::PH_SKIP) begin
							phase_q <= fpl_pkg::PH_RESYNC;
						end else begin
							phase_q <= fpl_pkg::PH_RUNNING;
							if (start_eff == '0) begin
								count_q <= '0;
								start_q <= now_q;
							end else begin
								count_q <= count_new;
								start_q <= start_eff;
							end
						end
					end
					fpl_pkg::OP_SPEED_UP, fpl_pkg::OP_SPEED_DOWN,
					fpl_pkg::OP_SET_SPEED: begin
						target_q <= speed_new;
						count_q  <= '0;
						phase_q  <= fpl_pkg::PH_RUNNING;
					end
					fpl_pkg::OP_RESTART:
						phase_q <= fpl_pkg::PH_SKIP;
					fpl_pkg::OP_ADJUST:
						start_q <= start_q + {{(TW - fpl_pkg::ADJ_W){adj_q[fpl_pkg::ADJ_W-1]}},
							adj_q};
					default: ;
				endcase
			end else if (cmd.step == fpl_pkg::CMD_FINISH && close) begin
				count_q <= '0;
				start_q <= start_next;
			end
		end
	end

	// request latch, frame pipeline and result
	always_ff @(posedge clk) begin
		case (cmd.step)
			fpl_pkg::CMD_LOAD: begin
				op_q  <= fpl_pkg::op_t'(op);
				now_q <= now_us;
				req_q <= speed_value;
				adj_q <= adjust_us;
			end
			fpl_pkg::CMD_DECODE: begin
				wait_q  <= '0;
				valid_q <= 1'b0;
				fps_q   <= '0;
				done_q  <= (op_q == fpl_pkg::OP_FRAME) && (phase_q != fpl_pkg::PH_SKIP)
					&& (start_eff == '0);
			end
			fpl_pkg::CMD_MUL: begin
				prod_s1        <= PRW'(period_q * count_q);
				early_close_s1 <= (now_q < start_q)
					|| ((now_q - start_q) >= TW'(fpl_pkg::US_PER_SECOND));
			end
			fpl_pkg::CMD_DUE:
				due_s2 <= {1'b0, start_q} + DW'(prod_s1);
			fpl_pkg::CMD_DIFF:
				diff_s3 <= {2'b00, now_q} - {1'b0, due_s2};
			fpl_pkg::CMD_FINISH: begin
				wait_q <= early ? wait_sat : '0;
				if (close) begin
					fps_q   <= count_q;
					valid_q <= 1'b1;
					done_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// status to the controller
	always_comb begin
		stat.op          = op_q;
		stat.frame_skip  = phase_q == fpl_pkg::PH_SKIP;
		stat.frame_short = start_eff == '0;
		stat.div_done    = div_done;
	end

	assign res_wait  = wait_q;
	assign res_done  = done_q;
	assign res_valid = valid_q;
	assign res_fps   = fps_q;
	assign res_speed = target_q;

endmodule

`default_nettype wire

// ===== hdl/fpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpl_ctrl
// Sequencer for one request: decode, frame math steps, divider wait, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               cfg_wr,
	input  wire logic               out_free,
	input  wire fpl_pkg::dp_stat_t  stat,
	output fpl_pkg::ctrl_cmd_t      cmd
);

	fpl_pkg::ctrl_state_t state_q;
	fpl_pkg::ctrl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fpl_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fpl_pkg::ST_IDLE: begin
				if (cfg_wr)
					state_nxt = fpl_pkg::ST_CFG_WAIT;
				else if (in_valid)
					state_nxt = fpl_pkg::ST_DECODE;
			end
			fpl_pkg::ST_DECODE: begin
				case (stat.op)
					fpl_pkg::OP_FRAME:
						state_nxt = (stat.frame_skip || stat.frame_short)
							? fpl_pkg::ST_EMIT : fpl_pkg::ST_MUL;
					fpl_pkg::OP_SPEED_UP, fpl_pkg::OP_SPEED_DOWN,
					fpl_pkg::OP_SET_SPEED:
						state_nxt = fpl_pkg::ST_DIV_WAIT;
					default:
						state_nxt = fpl_pkg::ST_EMIT;
				endcase
			end
			fpl_pkg::ST_MUL:    state_nxt = fpl_pkg::ST_DUE;
			fpl_pkg::ST_DUE:    state_nxt = fpl_pkg::ST_DIFF;
			fpl_pkg::ST_DIFF:   state_nxt = fpl_pkg::ST_FINISH;
			fpl_pkg::ST_FINISH: state_nxt = fpl_pkg::ST_EMIT;
			fpl_pkg::ST_DIV_WAIT: begin
				if (stat.div_done)
					state_nxt = fpl_pkg::ST_EMIT;
			end
			fpl_pkg::ST_CFG_WAIT: begin
				if (stat.div_done)
					state_nxt = fpl_pkg::ST_IDLE;
			end
			fpl_pkg::ST_EMIT: begin
				if (out_free)
					state_nxt = fpl_pkg::ST_IDLE;
			end
			default: state_nxt = fpl_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.step     = fpl_pkg::CMD_IDLE;
		cmd.in_ready = 1'b0;
		cmd.emit     = 1'b0;
		case (state_q)
			fpl_pkg::ST_IDLE: begin
				cmd.in_ready = !cfg_wr;
				if (!cfg_wr && in_valid)
					cmd.step = fpl_pkg::CMD_LOAD;
			end
			fpl_pkg::ST_DECODE: cmd.step = fpl_pkg::CMD_DECODE;
			fpl_pkg::ST_MUL:    cmd.step = fpl_pkg::CMD_MUL;
			fpl_pkg::ST_DUE:    cmd.step = fpl_pkg::CMD_DUE;
			fpl_pkg::ST_DIFF:   cmd.step = fpl_pkg::CMD_DIFF;
			fpl_pkg::ST_FINISH: cmd.step = fpl_pkg::CMD_FINISH;
			fpl_pkg::ST_EMIT:   cmd.emit = out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/frame_pacing_limiter.sv =====
// ----------------------------------------------------------------------------
// frame_pacing_limiter
// Frame-rate pacer: wait time per frame, window frame counts, speed control.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    op, now_us, speed_value, adjust_us
//   out      source     out_valid / out_stall  wait_us, window_done, fps_valid,
//                                              fps, speed
//   apb      slave      psel / penable         paddr, pwdata, prdata (hertz)
//
// One request at a time. A counted frame reaches the result register through
// decode, multiply, due add, difference, finish and emit; other events pass
// decode and emit, speed events also wait for the period from the bit-serial
// divider (20 iterations). A hertz write keeps the input stalled while the
// divider runs. Reset loads 60 Hz and its period directly. The result
// register frees the sequencer; a stalled result blocks the next emit only.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_limiter #(
	parameter int MAX_SPEED = fpl_pkg::MAX_SPEED_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input request channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [fpl_pkg::OP_W-1:0]     op,
	input  wire logic        [fpl_pkg::TIME_W-1:0]   now_us,
	input  wire logic        [fpl_pkg::SPEED_W-1:0]  speed_value,
	input  wire logic signed [fpl_pkg::ADJ_W-1:0]    adjust_us,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [fpl_pkg::WAIT_W-1:0]   wait_us,
	output logic                                     window_done,
	output logic                                     fps_valid,
	output logic             [fpl_pkg::COUNT_W-1:0]  fps,
	output logic             [fpl_pkg::SPEED_W-1:0]  speed,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic        [2:0]                   paddr,
	input  wire logic        [31:0]                  pwdata,
	output logic             [31:0]                  prdata,
	output logic                                     pready
);

	localparam int SW = fpl_pkg::SPEED_W;

	logic [SW-1:0]                 hertz_q;
	logic                          cfg_wr;
	logic                          out_valid_q;
	logic                          out_free;
	fpl_pkg::ctrl_cmd_t            cmd;
	fpl_pkg::dp_stat_t             stat;
	logic [fpl_pkg::WAIT_W-1:0]    res_wait;
	logic                          res_done;
	logic                          res_valid;
	logic [fpl_pkg::COUNT_W-1:0]   res_fps;
	logic [SW-1:0]                 res_speed;
	logic [fpl_pkg::WAIT_W-1:0]    wait_q;
	logic                          done_q;
	logic                          valid_q;
	logic [fpl_pkg::COUNT_W-1:0]   fps_q;
	logic [SW-1:0]                 speed_q;

	// register file: hertz at byte addresses zero to three
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32 - SW){1'b0}}, hertz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hertz_q <= SW'(fpl_pkg::DEFAULT_SPEED);
		else if (cfg_wr)
			hertz_q <= pwdata[SW-1:0];
	end

	fpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_wr   (cfg_wr),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	fpl_dp #(
		.MAX_SPEED (MAX_SPEED)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr      (cfg_wr),
		.cfg_hertz   (pwdata[SW-1:0]),
		.op          (op),
		.now_us      (now_us),
		.speed_value (speed_value),
		.adjust_us   (adjust_us),
		.res_wait    (res_wait),
		.res_done    (res_done),
		.res_valid   (res_valid),
		.res_fps     (res_fps),
		.res_speed   (res_speed)
	);

	assign in_stall = !cmd.in_ready;

	// result register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			wait_q  <= res_wait;
			done_q  <= res_done;
			valid_q <= res_valid;
			fps_q   <= res_fps;
			speed_q <= res_speed;
		end
	end

	assign out_valid   = out_valid_q;
	assign wait_us     = wait_q;
	assign window_done = done_q;
	assign fps_valid   = valid_q;
	assign fps         = fps_q;
	assign speed       = speed_q;

endmodule

`default_nettype wire

// ===== hdl/fpl_checker.sv =====
// ----------------------------------------------------------------------------
// fpl_checker
// Port-level checks of the frame pacing limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [30:0] wait_us,
	input wire logic        window_done,
	input wire logic        fps_valid,
	input wire logic [15:0] fps,
	input wire logic [9:0]  speed
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(wait_us) && $stable(fps)
			&& $stable(speed) && $stable(window_done) && $stable(fps_valid))
		else $error("result changed while stalled");

	// speed never drops to zero
	a_speed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> speed != 10'd0)
		else $error("zero speed reported");

	// a reported count always comes with a closed window
	a_fps_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fps_valid |-> window_done)
		else $error("fps reported without window close");

	// no count without a report
	a_fps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fps_valid |-> fps == 16'd0)
		else $error("fps set without fps_valid");

	// a window opened on an unstarted start has no wait
	a_open_nowait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_done && !fps_valid |-> wait_us == 31'd0)
		else $error("wait on window open");

endmodule

bind frame_pacing_limiter fpl_checker u_fpl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.wait_us     (wait_us),
	.window_done (window_done),
	.fps_valid   (fps_valid),
	.fps         (fps),
	.speed       (speed)
);

`default_nettype wire

// ===== test/frame_pacing_limiter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_limiter_test
// Self-checking bench for the frame pacer. Frame, speed, restart and time
// adjust requests are driven with random gaps on both channels. A shadow copy
// of the pacing state predicts every result, which is matched in order
// against the result channel. The hertz register is rewritten between phases,
// and the result side stalls for long stretches so that the block backs up
// into its input.
// ----------------------------------------------------------------------------

module frame_pacing_limiter_test;

	localparam logic [fpl_pkg::WAIT_W-1:0] WAIT_MAX    = 31'h7FFF_FFFF;
	localparam logic [2:0]                 HERTZ_ADDR  = 3'd0;
	localparam logic [fpl_pkg::OP_W-1:0]   OP_SPARE_A  = 3'd6;
	localparam logic [fpl_pkg::OP_W-1:0]   OP_SPARE_B  = 3'd7;
	localparam int unsigned                CYCLE_LIMIT = 4_000_000;
	localparam int unsigned                HOLD_CYCLES = 600;
	localparam int unsigned                DRAIN_CYCLES = 64;
	localparam int unsigned                PHASE_ITEMS = 200;

	typedef struct packed {
		logic [fpl_pkg::WAIT_W-1:0]  wait_us;
		logic                        window_done;
		logic                        fps_valid;
		logic [fpl_pkg::COUNT_W-1:0] fps;
		logic [fpl_pkg::SPEED_W-1:0] speed;
	} pace_result_t;

	// shadow of the pacing state and the results it still owes
	class pacing_tracker;
		logic [fpl_pkg::SPEED_W-1:0]  target_speed;
		logic [fpl_pkg::PERIOD_W-1:0] period_us;
		logic [fpl_pkg::COUNT_W-1:0]  frame_count;
		fpl_pkg::phase_t              phase;
		logic [fpl_pkg::TIME_W-1:0]   window_start;
		pace_result_t                 pending_paces[$];
		int unsigned                  faults;

		function new();
			faults = 0;
			set_speed(fpl_pkg::DEFAULT_SPEED);
			window_start = '0;
		endfunction

		// clamp, reload the period and restart counting
		function void set_speed(int unsigned s);
			if (s < 1)
				s = 1;
			else if (s > fpl_pkg::MAX_SPEED_DEF)
				s = fpl_pkg::MAX_SPEED_DEF;
			target_speed = fpl_pkg::SPEED_W'(s);
			period_us = fpl_pkg::PERIOD_W'(fpl_pkg::US_PER_SECOND / s);
			frame_count = '0;
			phase = fpl_pkg::PH_RUNNING;
		endfunction

		// band dependent step up or down
		function void step_speed(bit up);
			int unsigned s, step;
			s = target_speed;
			if (s >= fpl_pkg::DEFAULT_SPEED)
				step = fpl_pkg::STEP_HI;
			else if (s >= fpl_pkg::MID_BAND)
				step = fpl_pkg::STEP_MID;
			else
				step = fpl_pkg::STEP_LO;
			if (up)
				s = s + step;
			else if (s > step)
				s = s - step;
			else
				s = 1;
			set_speed(s);
		endfunction

		// advance the state by one accepted request and queue its result
		function void accept_event(logic [fpl_pkg::OP_W-1:0] code,
				logic [fpl_pkg::TIME_W-1:0] now, logic [fpl_pkg::SPEED_W-1:0] req,
				logic signed [fpl_pkg::ADJ_W-1:0] adj);
			pace_result_t r;
			logic [63:0]  t, start, due, d;
			bit           closing;
			r = '0;
			t = {16'd0, now};
			case (code)
				fpl_pkg::OP_FRAME: begin
					if (phase == fpl_pkg::PH_SKIP) begin
						phase = fpl_pkg::PH_RESYNC;
					end else begin
						if (phase == fpl_pkg::PH_RESYNC) begin
							frame_count = '0;
							window_start = now;
							phase = fpl_pkg::PH_RUNNING;
						end
						if (frame_count != '1)
							frame_count++;
						if (window_start == '0) begin
							// first frame opens the window
							frame_count = '0;
							window_start = now;
							r.window_done = 1'b1;
						end else begin
							start = {16'd0, window_start};
							due = start + 64'(period_us) * 64'(frame_count);
							closing = (t < start) || (t - start >= fpl_pkg::US_PER_SECOND);
							if (t < due) begin
								// early: wait, then continue from the due time
								d = due - t;
								r.wait_us = (d > 64'(WAIT_MAX)) ? WAIT_MAX
									: d[fpl_pkg::WAIT_W-1:0];
								t = {16'd0, due[fpl_pkg::TIME_W-1:0]};
							end else begin
								closing = (t - due) > fpl_pkg::LATE_LIMIT_US;
							end
							if (closing) begin
								r.fps = frame_count;
								r.fps_valid = 1'b1;
								r.window_done = 1'b1;
								frame_count = '0;
								window_start = t[fpl_pkg::TIME_W-1:0];
							end
						end
					end
				end
				fpl_pkg::OP_SPEED_UP:   step_speed(1'b1);
				fpl_pkg::OP_SPEED_DOWN: step_speed(1'b0);
				fpl_pkg::OP_SET_SPEED:  set_speed(req);
				fpl_pkg::OP_RESTART:    phase = fpl_pkg::PH_SKIP;
				fpl_pkg::OP_ADJUST:
					window_start = window_start + {{16{adj[fpl_pkg::ADJ_W-1]}}, adj};
				default: ;
			endcase
			r.speed = target_speed;
			pending_paces.insert(pending_paces.size(), r);
		endfunction

		// compare one delivered result with the oldest one owed
		function void match_result(pace_result_t got);
			pace_result_t want;
			if (pending_paces.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: wait %0d done %b fps_valid %b fps %0d speed %0d",
						got.wait_us, got.window_done, got.fps_valid, got.fps, got.speed);
				return;
			end
			want = pending_paces.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display({"result mismatch (expected/actual): wait %0d/%0d done %b/%b ",
						"fps_valid %b/%b fps %0d/%0d speed %0d/%0d"},
						want.wait_us, got.wait_us, want.window_done, got.window_done,
						want.fps_valid, got.fps_valid, want.fps, got.fps,
						want.speed, got.speed);
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [fpl_pkg::OP_W-1:0]           op;
	logic [fpl_pkg::TIME_W-1:0]         now_us;
	logic [fpl_pkg::SPEED_W-1:0]        speed_value;
	logic signed [fpl_pkg::ADJ_W-1:0]   adjust_us;
	logic                               out_valid;
	logic                               out_stall;
	logic [fpl_pkg::WAIT_W-1:0]         wait_us;
	logic                               window_done;
	logic                               fps_valid;
	logic [fpl_pkg::COUNT_W-1:0]        fps;
	logic [fpl_pkg::SPEED_W-1:0]        speed;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [2:0]                         paddr;
	logic [31:0]                        pwdata;
	logic [31:0]                        prdata;
	logic                               pready;

	pacing_tracker tracker = new();
	int unsigned   send_calm;
	int unsigned   take_calm;
	int unsigned   cycles;
	logic [9:0]    hertz_plan[6] = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd60, 10'd60};

	frame_pacing_limiter u_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// idle cycles before the next request or result, with calm stretches
	function automatic int unsigned draw_gap(inout int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic logic [fpl_pkg::TIME_W-1:0] rand48();
		rand48 = {16'($urandom()), $urandom()};
	endfunction

	// offer one request and wait until it is taken
	task automatic send_event(logic [fpl_pkg::OP_W-1:0] code,
			logic [fpl_pkg::TIME_W-1:0] t, logic [fpl_pkg::SPEED_W-1:0] spd,
			logic signed [fpl_pkg::ADJ_W-1:0] adj);
		int unsigned gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= code;
		now_us      <= t;
		speed_value <= spd;
		adjust_us   <= adj;
		do @(posedge clk); while (in_stall);
		tracker.accept_event(code, t, spd, adj);
	endtask

	// stop offering and let every owed result come out
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_paces.size() != 0) @(posedge clk);
	endtask

	// hertz register write: setup then access
	task automatic write_hertz(logic [9:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HERTZ_ADDR;
		pwdata  <= {22'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_speed(val);
	endtask

	// result side: random stalls, two long hold-offs
	initial begin : result_side
		int unsigned  gap, taken;
		pace_result_t got;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 200 || taken == 1000)
				gap = HOLD_CYCLES;
			else
				gap = draw_gap(take_calm);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.wait_us     = wait_us;
			got.window_done = window_done;
			got.fps_valid   = fps_valid;
			got.fps         = fps;
			got.speed       = speed;
			tracker.match_result(got);
			taken++;
		end
	end

	// request side
	initial begin : stimulus
		logic [fpl_pkg::OP_W-1:0]         code;
		logic [fpl_pkg::TIME_W-1:0]       t, base, last_t;
		logic [fpl_pkg::SPEED_W-1:0]      spd;
		logic signed [fpl_pkg::ADJ_W-1:0] adj;
		int unsigned                      pick, roll;

		send_calm = 0;
		take_calm = 0;
		last_t = '0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		op          <= fpl_pkg::OP_FRAME;
		now_us      <= '0;
		speed_value <= '0;
		adjust_us   <= '0;
		out_stall   <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: window opening, early, late and boundary frames
		send_event(fpl_pkg::OP_FRAME, 48'd5000, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_FRAME, 48'd5000 + 16666 - 100, 10'h3FF, -32'sd1);
		send_event(fpl_pkg::OP_FRAME, 48'd5000 + 2 * 16666 + 70001, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_FRAME, 48'd108333 + 16666 + 70000, 10'd0, 32'sd0);
		// window start far ahead: frame before start, saturated wait
		send_event(fpl_pkg::OP_ADJUST, rand48(), 10'($urandom_range(0, 1023)),
			32'sh7FFF_FFFF);
		send_event(fpl_pkg::OP_FRAME, 48'd7, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_ADJUST, rand48(), 10'($urandom_range(0, 1023)),
			32'sh8000_0000);
		// near the top of the time range: due time wraps past 48 bits
		send_event(fpl_pkg::OP_FRAME, 48'hFFFF_FFFF_FFF0, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_FRAME, 48'hFFFF_FFFF_FFF8, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_FRAME, 48'd3, 10'd0, 32'sd0);
		// speed bands and limits
		send_event(fpl_pkg::OP_SPEED_UP, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SPEED_DOWN, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SET_SPEED, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SPEED_DOWN, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SPEED_UP, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SET_SPEED, rand48(), 10'd14, $urandom);
		send_event(fpl_pkg::OP_SPEED_UP, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SPEED_DOWN, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_SET_SPEED, rand48(), 10'd1023, $urandom);
		send_event(fpl_pkg::OP_SPEED_UP, rand48(), 10'd0, $urandom);
		// restart: skipped frame, then resync
		send_event(fpl_pkg::OP_RESTART, rand48(), 10'd0, $urandom);
		send_event(fpl_pkg::OP_FRAME, 48'd900_000, 10'd0, 32'sd0);
		send_event(fpl_pkg::OP_FRAME, 48'd950_000, 10'd0, 32'sd0);
		// unused codes
		send_event(OP_SPARE_A, rand48(), 10'($urandom_range(0, 1023)), $urandom);
		send_event(OP_SPARE_B, rand48(), 10'($urandom_range(0, 1023)), $urandom);
		send_event(fpl_pkg::OP_SET_SPEED, rand48(), 10'd60, $urandom);

		// random phases, each under its own hertz setting
		hertz_plan[4] = 10'($urandom_range(2, 999));
		for (int p = 0; p < 6; p++) begin
			drain();
			write_hertz(hertz_plan[p]);
			for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
				t = rand48();
				spd = 10'($urandom_range(0, 1023));
				adj = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					code = fpl_pkg::OP_FRAME;
					// aim around the next due time
					if (tracker.window_start == '0 || tracker.phase != fpl_pkg::PH_RUNNING)
						base = last_t + tracker.period_us;
					else
						base = tracker.window_start +
							48'(tracker.period_us) * (48'(tracker.frame_count) + 48'd1);
					roll = $urandom_range(0, 99);
					if (roll < 50)
						t = base + $urandom_range(0, 3000) - 48'd1500;
					else if (roll < 68)
						t = base - $urandom_range(0, tracker.period_us);
					else if (roll < 80)
						t = base + $urandom_range(60000, 80000);
					else if (roll < 86)
						t = base + fpl_pkg::LATE_LIMIT_US + $urandom_range(0, 1);
					else if (roll < 89)
						t = tracker.window_start + fpl_pkg::US_PER_SECOND
							- $urandom_range(0, 1);
					else if (roll < 93)
						t = base + fpl_pkg::US_PER_SECOND + $urandom_range(0, 3_000_000);
					else if (roll < 96)
						t = base - $urandom_range(0, 3_000_000);
					last_t = t;
				end else if (pick < 84) begin
					code = fpl_pkg::OP_SPEED_UP;
				end else if (pick < 88) begin
					code = fpl_pkg::OP_SPEED_DOWN;
				end else if (pick < 91) begin
					code = fpl_pkg::OP_SET_SPEED;
				end else if (pick < 94) begin
					code = fpl_pkg::OP_RESTART;
				end else if (pick < 98) begin
					code = fpl_pkg::OP_ADJUST;
					if ($urandom_range(0, 1) == 0)
						adj = $signed($urandom_range(0, 2_000_000)) - 1_000_000;
				end else begin
					code = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
				end
				send_event(code, t, spd, adj);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_paces.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
